// File: rtl/dtu_pkg.sv
// Shared types and codes for the decimal text to 128-bit converter.
package dtu_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       has_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] value_high;
      logic [63:0] value_low;
      logic [2:0]  status;
   } rsp_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NONDIGIT = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_ZERO     = 3'd4;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NONDIGIT = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic [127:0] acc;
      logic         seen;
      err_type      err;
   } parse_state_type;

endpackage

// File: rtl/dtu_step.sv
// One character step: accumulator times ten plus digit, with error tracking.
module dtu_step
   import dtu_pkg::*;
(
   input  parse_state_type cur,
   input  req_type         item,
   output parse_state_type nxt
);

   logic [131:0] acc_wide;
   logic [131:0] prod;
   logic [3:0]   digit;
   logic         is_digit;

   assign acc_wide = {4'b0000, cur.acc};
   assign digit    = 4'(item.char_code - CHAR_ZERO);
   assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
   // x * 10 = (x << 3) + (x << 1)
   assign prod     = (acc_wide << 3) + (acc_wide << 1) + {128'd0, digit};

   always_comb begin
      nxt = cur;
      if (item.has_char) begin
         nxt.seen = 1'b1;
         if (cur.err == ERR_NONE) begin
            if (!is_digit) begin
               nxt.err = ERR_NONDIGIT;
            end else if (prod[131:128] != 4'd0) begin
               nxt.err = ERR_OVERFLOW;
            end else begin
               nxt.acc = prod[127:0];
            end
         end
      end
   end

endmodule

// File: rtl/dtu_result.sv
// Forms the result transaction from the parse state at the end of a string.
module dtu_result
   import dtu_pkg::*;
(
   input  parse_state_type st,
   output rsp_type         rsp
);

   always_comb begin
      rsp.value_high = 64'd0;
      rsp.value_low  = 64'd0;
      if (!st.seen) begin
         rsp.status = ST_EMPTY;
      end else if (st.err == ERR_NONDIGIT) begin
         rsp.status = ST_NONDIGIT;
      end else if (st.err != ERR_NONE) begin
         rsp.status = ST_OVERFLOW;
      end else begin
         rsp.value_high = st.acc[127:64];
         rsp.value_low  = st.acc[63:0];
         rsp.status     = (st.acc == 128'd0) ? ST_ZERO : ST_OK;
      end
   end

endmodule

// File: rtl/decimal_text_to_u128.sv
// Top level of the ASCII decimal string to 128-bit binary converter.
//
//   channel   direction  ports                             payload
//   req       in         req_valid, req_stall, req_data    req_type (one character)
//   rsp       out        rsp_valid, rsp_stall, rsp_data    rsp_type (value and status)
//
// One character is taken every cycle while no end marker waits. A transaction
// lands in the input register; the times-ten add and the status logic run in
// the cycle after, and the result register captures the end marker's result.
// Reset (synchronous, active high) empties both registers and clears the
// accumulator, the seen flag and the sticky error.
// While rsp stalls, characters keep flowing; an end marker waits and stalls req.
module decimal_text_to_u128
   import dtu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff, in_data_in;
   // Parse state
   parse_state_type state_ff, state_in;
   parse_state_type state_step;
   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;
   rsp_type         rsp_form;

   logic out_free;
   logic proceed;
   logic accept;

   dtu_step u_step (
      .cur  (state_ff),
      .item (in_data_ff),
      .nxt  (state_step)
   );

   dtu_result u_result (
      .st  (state_step),
      .rsp (rsp_form)
   );

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Characters without an end never need the result register.
   assign proceed  = in_valid_ff && (!in_data_ff.is_last || out_free);
   assign req_stall = in_valid_ff && !proceed;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (proceed) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (proceed) begin
         if (in_data_ff.is_last) begin
            // Emit the result and drop back to a fresh string.
            rsp_valid_in = 1'b1;
            rsp_data_in  = rsp_form;
            state_in     = '{acc: 128'd0, seen: 1'b0, err: ERR_NONE};
         end else begin
            state_in = state_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{acc: 128'd0, seen: 1'b0, err: ERR_NONE};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
